// File: sv/iq_magnitude_dc_block_top_macros.svh
// Assertion macros for the I/Q magnitude block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef IQ_MAGNITUDE_DC_BLOCK_TOP_MACROS_SVH
`define IQ_MAGNITUDE_DC_BLOCK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IMDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("imdc check failed");
`define IMDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("imdc check failed");
`else
`define IMDC_ASSERT(lbl, clk, rst_n, prop)
`define IMDC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/imdc_pkg.sv
// Shared types, widths and codes for the I/Q magnitude block.
// No dependencies; imported by every module of the block.
`default_nettype none
package imdc_pkg;
    localparam int BLOCK_COUNT_BITS_DEF = 20;
    localparam int QUEUE_DEPTH          = 2;

    localparam int X_W    = 46;   // normalised sample, Q.40 signed
    localparam int Z_W    = 48;   // DC estimate
    localparam int D_W    = 49;   // sample minus estimate
    localparam int CH_W   = 17;   // multiplier chunk of the difference
    localparam int ACC_W  = 84;
    localparam int R_W    = 32;   // sample rounded to Q.24
    localparam int MSQ_W  = 64;
    localparam int MAG_W  = 20;
    localparam int MP_W   = 26;
    localparam int LSUM_W = 40;
    localparam int PSUM_W = 48;
    localparam int PWR_W  = 33;
    localparam int NUM_W  = 49;
    localparam int IT_W   = 6;
    localparam int ROOT_STEPS = 32;

    localparam logic [1:0] FMT_UC8  = 2'd0;
    localparam logic [1:0] FMT_SC16 = 2'd1;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_DC_EN  = 2'd1;
    localparam logic [1:0] REG_POLE   = 2'd2;

    typedef struct packed {
        logic signed [X_W-1:0] x_i;
        logic signed [X_W-1:0] x_q;
        logic                  blk_end;
    } t_item;

    typedef struct packed {
        logic [1:0]  fmt;
        logic        dc_en;
        logic [31:0] pole;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL, S_UPD, S_RND, S_SQR, S_ROOT, S_ACC, S_DLD, S_DIV, S_FIN
    } t_state;
endpackage
`default_nettype wire

// File: sv/iq_magnitude_dc_block_top.sv
// I/Q magnitude with DC blocking and block statistics: top level.
// Input channel: i_valid/o_ready with i_sample_i, i_sample_q, i_block_end; one
// result per item on o_valid/i_ready with o_magnitude, o_mean_level,
// o_mean_power and o_means_valid.
// Configuration: write i_cfg_wdata to register i_cfg_addr while i_cfg_we is
// high (0 format, 1 DC block enable, 2 pole); write only while idle.
// Items are scaled by the front end into a two-entry queue and run one at a
// time through the sequencer. Per item: a load step, the two DC tracker
// updates when enabled (17-bit chunks through one multiplier), rounding and
// squaring, a bit-serial square root and accumulation, then the hand-over of
// the result. The last item of a block adds the two mean divisions, which run
// side by side one quotient bit a cycle.
// Reset clears the DC estimates, the sums, the queue and the result valid flags.
// A stalled receiver holds the result register; the sequencer still finishes
// the next item and the queue keeps taking items until it is full.
`default_nettype none
module iq_magnitude_dc_block_top #(
    parameter int BLOCK_COUNT_BITS = imdc_pkg::BLOCK_COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH      = imdc_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [31:0]                i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [15:0]                i_sample_i,
    input  logic [15:0]                i_sample_q,
    input  logic                       i_block_end,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [imdc_pkg::MAG_W-1:0] o_magnitude,
    output logic [imdc_pkg::MAG_W-1:0] o_mean_level,
    output logic [imdc_pkg::MP_W-1:0]  o_mean_power,
    output logic                       o_means_valid
);
    import imdc_pkg::*;

    t_cfg  r_cfg;
    t_item w_front_item, w_queue_item;
    logic  w_full_n, w_empty_n, w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt   <= FMT_UC8;
            r_cfg.dc_en <= 1'b0;
            r_cfg.pole  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FORMAT: begin
                    r_cfg.fmt <= i_cfg_wdata[1:0];
                end
                REG_DC_EN: begin
                    r_cfg.dc_en <= i_cfg_wdata[0];
                end
                REG_POLE: begin
                    r_cfg.pole <= i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_ready = w_full_n;
    assign w_push  = i_valid && w_full_n;

    imdc_front u_front (
        .i_fmt       (r_cfg.fmt),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .i_block_end (i_block_end),
        .o_item      (w_front_item)
    );

    imdc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_item    (w_front_item),
        .i_pop     (w_pop),
        .o_item    (w_queue_item),
        .o_full_n  (w_full_n),
        .o_empty_n (w_empty_n)
    );

    imdc_back #(
        .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item        (w_queue_item),
        .i_item_valid  (w_empty_n),
        .o_pop         (w_pop),
        .o_magnitude   (o_magnitude),
        .o_mean_level  (o_mean_level),
        .o_mean_power  (o_mean_power),
        .o_means_valid (o_means_valid),
        .o_valid       (o_valid),
        .i_ready       (i_ready)
    );
endmodule
`default_nettype wire

// File: sv/imdc_front.sv
// Front end: decodes the sample format and scales both words to Q.40.
// Depends on imdc_pkg.
`default_nettype none
module imdc_front (
    input  logic [1:0]     i_fmt,
    input  logic [15:0]    i_sample_i,
    input  logic [15:0]    i_sample_q,
    input  logic           i_block_end,
    output imdc_pkg::t_item o_item
);
    import imdc_pkg::*;

    function automatic logic signed [X_W-1:0] to_q40(input logic [15:0] raw,
                                                     input logic [1:0] fmt);
        logic signed [8:0]     d8;
        logic [15:0]           m;
        logic [25:0]           t;
        logic [15:0]           r;
        logic                  qc;
        logic [41:0]           q;
        logic signed [X_W-1:0] res;
        d8 = raw[7] ? $signed({1'b0, raw[7:0]}) - 9'sd127
                    : $signed({1'b0, raw[7:0]}) - 9'sd128;
        m  = raw[15] ? 16'(-raw) : raw;
        // 2^40 = 32767 * (2^25 + 2^10) + 2^10: only the small remainder is divided
        t  = {m, 10'b0} + 26'd16383;
        r  = {1'b0, t[14:0]} + {5'b0, t[25:15]};
        qc = (r >= 16'd32767);
        q  = 42'({m, 25'b0}) + 42'({m, 10'b0}) + 42'(t[25:15]) + 42'(qc);
        case (fmt)
            FMT_UC8: begin
                res = X_W'(d8) <<< 33;
            end
            FMT_SC16: begin
                res = raw[15] ? -$signed({4'b0, q}) : $signed({4'b0, q});
            end
            default: begin
                res = X_W'($signed(raw)) <<< 29;
            end
        endcase
        return res;
    endfunction

    assign o_item.x_i     = to_q40(i_sample_i, i_fmt);
    assign o_item.x_q     = to_q40(i_sample_q, i_fmt);
    assign o_item.blk_end = i_block_end;
endmodule
`default_nettype wire

// File: sv/imdc_fifo.sv
// Short queue between the front end and the sequencer.
// Depends on imdc_pkg for the item type.
`default_nettype none
module imdc_fifo #(
    parameter int DEPTH = imdc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  imdc_pkg::t_item i_item,
    input  logic            i_pop,
    output imdc_pkg::t_item o_item,
    output logic            o_full_n,
    output logic            o_empty_n
);
    import imdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= step(r_wr);
            end
            if (i_pop) begin
                r_rd <= step(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_item    = r_mem[r_rd];
    assign o_full_n  = (r_cnt != CNT_W'(DEPTH));
    assign o_empty_n = (r_cnt != '0);
endmodule
`default_nettype wire

// File: sv/imdc_back.sv
// Back end sequencer: DC tracker, magnitude, block sums and means.
// Depends on imdc_pkg and the assertion macro header.
`default_nettype none
`include "iq_magnitude_dc_block_top_macros.svh"
module imdc_back #(
    parameter int BLOCK_COUNT_BITS = imdc_pkg::BLOCK_COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  imdc_pkg::t_cfg            i_cfg,
    input  imdc_pkg::t_item           i_item,
    input  logic                      i_item_valid,
    output logic                      o_pop,
    output logic [imdc_pkg::MAG_W-1:0] o_magnitude,
    output logic [imdc_pkg::MAG_W-1:0] o_mean_level,
    output logic [imdc_pkg::MP_W-1:0]  o_mean_power,
    output logic                      o_means_valid,
    output logic                      o_valid,
    input  logic                      i_ready
);
    import imdc_pkg::*;

    localparam int CNT_W = BLOCK_COUNT_BITS;
    localparam int REM_W = CNT_W + 1;

    t_state r_state, n_state;

    logic signed [X_W-1:0]   r_xi, r_xq;
    logic                    r_end;
    logic signed [Z_W-1:0]   r_zi, r_zq;
    logic                    r_ch;
    logic [1:0]              r_k;
    logic signed [D_W-1:0]   r_d;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [R_W-1:0]   r_rnd;
    logic [MSQ_W-1:0]        r_msq, r_v, r_res, r_bit;
    logic [IT_W-1:0]         r_it;
    logic [LSUM_W-1:0]       r_lsum;
    logic [PSUM_W-1:0]       r_psum;
    logic [CNT_W-1:0]        r_count;
    logic [MAG_W-1:0]        r_mag;
    logic [NUM_W-1:0]        r_num_l, r_num_p, r_q_l, r_q_p;
    logic [REM_W-1:0]        r_rem_l, r_rem_p;
    logic                    r_out_valid, r_mv;
    logic [MAG_W-1:0]        r_omag, r_ml;
    logic [MP_W-1:0]         r_mp;

    logic                    w_out_free, w_out_load;
    logic [32:0]             w_a;
    logic signed [X_W-1:0]   w_x_ch;
    logic signed [Z_W-1:0]   w_z_ch, w_zsub, w_z_new;
    logic [D_W+1:0]          w_d_ext;
    logic signed [CH_W:0]    w_chunk;
    logic signed [51:0]      w_prod;
    logic signed [ACC_W-1:0] w_pp;
    logic signed [D_W-1:0]   w_yr;
    logic signed [2*R_W-1:0] w_sq;
    logic [MSQ_W-1:0]        w_msq_new, w_trial;
    logic [32:0]             w_mag_sum;
    logic [MAG_W-1:0]        w_mag;
    logic [MSQ_W:0]          w_pwr_sum;
    logic [PWR_W-1:0]        w_pwr;
    logic [LSUM_W:0]         w_lsum_new;
    logic [PSUM_W:0]         w_psum_new;
    logic [REM_W-1:0]        w_dvs, w_sh_l, w_sh_p;
    logic                    w_ge_l, w_ge_p;

    // datapath
    assign w_a     = {1'b1, 32'b0} - {1'b0, i_cfg.pole};
    assign w_x_ch  = r_ch ? r_xq : r_xi;
    assign w_z_ch  = r_ch ? r_zq : r_zi;
    assign w_zsub  = i_cfg.dc_en ? w_z_ch : '0;
    assign w_d_ext = {{2{r_d[D_W-1]}}, r_d};

    always_comb begin
        case (r_k)
            2'd0: begin
                w_chunk = $signed({1'b0, w_d_ext[CH_W-1:0]});
            end
            2'd1: begin
                w_chunk = $signed({1'b0, w_d_ext[2*CH_W-1:CH_W]});
            end
            default: begin
                w_chunk = $signed({w_d_ext[D_W+1], w_d_ext[D_W+1:2*CH_W]});
            end
        endcase
    end

    assign w_prod = w_chunk * $signed({1'b0, w_a});

    always_comb begin
        case (r_k)
            2'd0: begin
                w_pp = ACC_W'(w_prod);
            end
            2'd1: begin
                w_pp = ACC_W'(w_prod) <<< CH_W;
            end
            default: begin
                w_pp = ACC_W'(w_prod) <<< (2 * CH_W);
            end
        endcase
    end

    assign w_z_new   = w_z_ch + $signed(r_acc[32 +: Z_W]);
    assign w_yr      = D_W'(w_x_ch) - D_W'(w_zsub) + D_W'(32768);
    assign w_sq      = r_rnd * r_rnd;
    assign w_msq_new = r_msq + MSQ_W'(w_sq);
    assign w_trial   = r_res + r_bit;

    assign w_mag_sum = {1'b0, r_res[31:0]} + 33'd128;
    assign w_mag     = (|w_mag_sum[32:28]) ? '1 : w_mag_sum[27:8];
    assign w_pwr_sum = {1'b0, r_msq} + (MSQ_W+1)'(32'h8000_0000);
    assign w_pwr     = w_pwr_sum[MSQ_W:32];
    assign w_lsum_new = {1'b0, r_lsum} + (LSUM_W+1)'(w_mag);
    assign w_psum_new = {1'b0, r_psum} + (PSUM_W+1)'(w_pwr);

    assign w_dvs  = {1'b0, r_count};
    assign w_sh_l = {r_rem_l[REM_W-2:0], r_num_l[NUM_W-1]};
    assign w_sh_p = {r_rem_p[REM_W-2:0], r_num_p[NUM_W-1]};
    assign w_ge_l = (w_sh_l >= w_dvs);
    assign w_ge_p = (w_sh_p >= w_dvs);

    assign w_out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = i_cfg.dc_en ? S_DIFF : S_RND;
                end
            end
            S_DIFF: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_k == 2'd2) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = r_ch ? S_RND : S_DIFF;
            end
            S_RND: begin
                n_state = S_SQR;
            end
            S_SQR: begin
                n_state = r_ch ? S_ROOT : S_RND;
            end
            S_ROOT: begin
                if (r_it == IT_W'(ROOT_STEPS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_end ? S_DLD : S_FIN;
            end
            S_DLD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_it == IT_W'(NUM_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_item_valid;
            end
            S_FIN: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_pop      = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_xi  <= i_item.x_i;
                r_xq  <= i_item.x_q;
                r_end <= i_item.blk_end;
                r_ch  <= 1'b0;
                r_msq <= '0;
            end
            S_DIFF: begin
                r_d   <= D_W'(w_x_ch) - D_W'(w_z_ch);
                r_k   <= 2'd0;
                r_acc <= {{(ACC_W-32){1'b0}}, 32'h8000_0000};
            end
            S_MUL: begin
                r_acc <= r_acc + w_pp;
                r_k   <= r_k + 2'd1;
            end
            S_UPD: begin
                r_ch <= !r_ch;
            end
            S_RND: begin
                r_rnd <= R_W'(w_yr >>> 16);
            end
            S_SQR: begin
                r_msq <= w_msq_new;
                r_ch  <= !r_ch;
                r_v   <= w_msq_new;
                r_res <= '0;
                r_bit <= MSQ_W'(1) << (MSQ_W - 2);
                r_it  <= '0;
            end
            S_ROOT: begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_it  <= r_it + 1'b1;
            end
            S_ACC: begin
                r_mag <= w_mag;
            end
            S_DLD: begin
                r_num_l <= NUM_W'(r_lsum) + NUM_W'(r_count >> 1);
                r_num_p <= NUM_W'(r_psum) + NUM_W'(r_count >> 1);
                r_rem_l <= '0;
                r_rem_p <= '0;
                r_it    <= '0;
            end
            S_DIV: begin
                r_rem_l <= w_ge_l ? w_sh_l - w_dvs : w_sh_l;
                r_rem_p <= w_ge_p ? w_sh_p - w_dvs : w_sh_p;
                r_q_l   <= {r_q_l[NUM_W-2:0], w_ge_l};
                r_q_p   <= {r_q_p[NUM_W-2:0], w_ge_p};
                r_num_l <= r_num_l << 1;
                r_num_p <= r_num_p << 1;
                r_it    <= r_it + 1'b1;
            end
            default: begin
                r_it <= r_it;
            end
        endcase
    end

    // persistent state: DC estimates, block sums and the result valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zi        <= '0;
            r_zq        <= '0;
            r_lsum      <= '0;
            r_psum      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_mv        <= 1'b0;
        end else begin
            if (r_state == S_UPD) begin
                if (r_ch) begin
                    r_zq <= w_z_new;
                end else begin
                    r_zi <= w_z_new;
                end
            end
            if (r_state == S_ACC) begin
                r_lsum <= w_lsum_new[LSUM_W] ? '1 : w_lsum_new[LSUM_W-1:0];
                r_psum <= w_psum_new[PSUM_W] ? '1 : w_psum_new[PSUM_W-1:0];
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_mv        <= r_end;
                if (r_end) begin
                    r_lsum  <= '0;
                    r_psum  <= '0;
                    r_count <= '0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_omag <= r_mag;
            if (r_end) begin
                r_ml <= (|r_q_l[NUM_W-1:MAG_W]) ? '1 : r_q_l[MAG_W-1:0];
                r_mp <= (|r_q_p[NUM_W-1:MP_W]) ? '1 : r_q_p[MP_W-1:0];
            end else begin
                r_ml <= '0;
                r_mp <= '0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_magnitude   = r_omag;
    assign o_mean_level  = r_ml;
    assign o_mean_power  = r_mp;
    assign o_means_valid = r_mv;

    `IMDC_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DLD) |-> (r_count != '0))
    `IMDC_ASSERT(a_dc_hold, i_clk, i_rst_n, (r_state != S_UPD) |=> ($stable(r_zi) && $stable(r_zq)))
    `IMDC_ASSERT(a_blk_clear, i_clk, i_rst_n, (w_out_load && r_end) |=> (r_count == '0 && r_lsum == '0 && r_psum == '0 && r_mv))
endmodule
`default_nettype wire
